>>> src/lace_pkg.sv
// Shared types, status codes and the CRC byte step for the log append engine.
package lace_pkg;

   // Input word: one data byte with end-of-entry and no-byte flags
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       no_data;
   } req_type;

   // Result word, one per entry
   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] sequence_number;
      logic [31:0] entry_offset;
      logic [31:0] payload_length;
      logic [31:0] checksum;
      logic [31:0] free_bytes;
   } rsp_type;

   // Finished entry handed from front to back
   typedef struct packed {
      logic [31:0] length;
      logic [31:0] checksum;
   } ent_type;

   localparam logic [1:0] STATUS_APPENDED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam int unsigned ALIGN_MASK = 7;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> src/log_append_crc_engine.sv
// Top level of the log append engine with running CRC-32.
//
//  channel | ports                          | word
//  --------+--------------------------------+------------------------------------
//  input   | req_valid, req_ready, req_data | one data byte, last, no_data
//  result  | rsp_valid, rsp_ready, rsp_data | status, sequence, offset, length...
//  config  | csr_valid, csr_ready, csr_data | log capacity in bytes
//
// One input word per cycle while the entry queue has room; the CRC byte step in the front end sets that rate.
// The result of an entry passes through the entry queue and is then registered in the output register.
// The two-entry queue lets the front keep taking words while a result waits.
// Synchronous reset; csr_ready is always high.
module log_append_crc_engine
   import lace_pkg::*;
#(
   parameter int unsigned ENTRY_HEADER_BYTES = 24,
   parameter int unsigned LOG_HEADER_BYTES   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic    fq_valid, fq_ready, qb_valid, qb_ready;
   ent_type fq_data, qb_data;

   assign csr_ready = 1'b1;

   lace_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .ent_valid (fq_valid),
      .ent_ready (fq_ready),
      .ent_data  (fq_data)
   );

   lace_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   lace_back #(
      .ENTRY_HEADER_BYTES (ENTRY_HEADER_BYTES),
      .LOG_HEADER_BYTES   (LOG_HEADER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .ent_valid (qb_valid),
      .ent_ready (qb_ready),
      .ent_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/lace_front.sv
// Front end: takes data words, keeps running CRC and byte count, emits finished entries.
module lace_front
   import lace_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    ent_valid,
   input  logic    ent_ready,
   output ent_type ent_data
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] crc_upd, count_upd;
   logic        accept;

   // Stall only when the entry queue has no room
   assign req_ready = ent_ready;
   assign accept    = req_valid & req_ready;

   // Fold in this word's byte
   always_comb begin
      crc_upd   = crc_ff;
      count_upd = count_ff;
      if (!req_data.no_data) begin
         crc_upd = crc_byte(crc_ff, req_data.data_byte);
         if (count_ff != ALL_ONES) begin
            count_upd = count_ff + 32'd1;
         end
      end
   end

   // Hand off on the last word; an empty entry carries CRC zero by construction
   assign ent_valid         = accept & req_data.last;
   assign ent_data.length   = count_upd;
   assign ent_data.checksum = crc_upd ^ ALL_ONES;

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_data.last) begin
            crc_in   = ALL_ONES;
            count_in = 32'd0;
         end else begin
            crc_in   = crc_upd;
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= ALL_ONES;
         count_ff <= 32'd0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/lace_queue.sv
// Short FIFO of finished entries between front and back.
module lace_queue
   import lace_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  ent_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output ent_type pop_data
);

   localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QPTR_W:0]   FULL_CNT  = (QPTR_W + 1)'(QUEUE_DEPTH);

   ent_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/lace_back.sv
// Back end: sizes each entry, checks it against capacity, places it if it fits and builds the result.
module lace_back
   import lace_pkg::*;
#(
   parameter int unsigned ENTRY_HEADER_BYTES = 24,
   parameter int unsigned LOG_HEADER_BYTES   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [31:0] csr_data,
   input  logic        ent_valid,
   output logic        ent_ready,
   input  ent_type     ent_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam logic [32:0] ENTRY_HDR = 33'(ENTRY_HEADER_BYTES);
   localparam logic [32:0] ROUND_UP  = 33'(ALIGN_MASK);
   localparam logic [31:0] LOG_HDR   = 32'(LOG_HEADER_BYTES);

   logic [31:0] capacity_ff;
   logic [63:0] seq_ff, seq_in;
   logic [31:0] wpos_ff, wpos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   rsp_type     result;

   logic        take, empty, fits;
   logic [32:0] raw_len, aligned;
   logic [33:0] end_pos, free_new;
   logic [31:0] free_old;

   // Take the next entry whenever the output register is free or draining
   assign take      = ent_valid & (~rsp_valid_ff | rsp_ready);
   assign ent_ready = ~rsp_valid_ff | rsp_ready;

   // Entry size and fit check against the current capacity
   assign raw_len    = {1'b0, ent_data.length} + ENTRY_HDR;
   assign aligned    = (raw_len + ROUND_UP) & ~ROUND_UP;
   assign end_pos    = {2'b00, wpos_ff} + {1'b0, aligned};
   assign free_new   = {2'b00, capacity_ff} - end_pos;
   assign fits       = (end_pos <= {2'b00, capacity_ff});
   assign free_old   = (wpos_ff > capacity_ff) ? 32'd0 : capacity_ff - wpos_ff;
   assign empty      = (ent_data.length == 32'd0);

   // Result word
   always_comb begin
      result.sequence_number = 64'd0;
      result.entry_offset    = 32'd0;
      result.payload_length  = ent_data.length;
      result.checksum        = ent_data.checksum;
      result.free_bytes      = free_old;
      if (empty) begin
         result.status = STATUS_EMPTY;
      end else if (!fits) begin
         result.status = STATUS_FULL;
      end else begin
         result.status          = STATUS_APPENDED;
         result.sequence_number = seq_ff;
         result.entry_offset    = wpos_ff;
         result.free_bytes      = free_new[31:0];
      end
   end

   // Log state and output register
   always_comb begin
      seq_in       = seq_ff;
      wpos_in      = wpos_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         if (!empty && fits) begin
            seq_in  = seq_ff + 64'd1;
            wpos_in = end_pos[31:0];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= 32'd65536;
         seq_ff       <= 64'd1;
         wpos_ff      <= LOG_HDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         seq_ff       <= seq_in;
         wpos_ff      <= wpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> dv/log_append_crc_engine_tb.sv
// Self-checking testbench for the log append engine: random entries, capacity sweeps, stalls.
module log_append_crc_engine_tb;
   import lace_pkg::*;

   localparam int unsigned ENTRY_HDR = 24;
   localparam int unsigned LOG_HDR   = 64;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data  = '0;

   // Predicted engine state
   logic [63:0] next_seq   = 64'd1;
   logic [31:0] log_tail   = LOG_HDR;
   logic [31:0] crc_reg    = ALL_ONES;
   logic [31:0] byte_tally = '0;
   logic [31:0] capacity   = 32'd65536;

   req_type queued_words[$];
   rsp_type awaited_results[$];

   int unsigned fail_count    = 0;
   int unsigned words_queued  = 0;
   int unsigned words_sent    = 0;
   int unsigned appended_seen = 0;
   int unsigned full_seen     = 0;
   int unsigned empty_seen    = 0;
   bit          steady        = 1'b0;
   int unsigned hold_asked    = 0;
   int unsigned holds_started = 0;
   int unsigned hold_left     = 0;

   log_append_crc_engine #(
      .ENTRY_HEADER_BYTES(ENTRY_HDR),
      .LOG_HEADER_BYTES(LOG_HDR)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Reflected CRC-32, fed one data bit at a time
   function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r  = r >> 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   // Advance the predicted state by one accepted word; queue a result on last
   task automatic predict_append(input req_type w);
      rsp_type     r;
      logic [63:0] padded;
      if (!w.no_data) begin
         crc_reg = crc_step(crc_reg, w.data_byte);
         if (byte_tally != ALL_ONES) byte_tally++;
      end
      if (w.last) begin
         r = '0;
         r.payload_length = byte_tally;
         r.checksum       = ~crc_reg;
         if (byte_tally == 0) begin
            r.status   = STATUS_EMPTY;
            r.checksum = '0;
         end else begin
            padded = (64'(ENTRY_HDR) + 64'(byte_tally) + 64'd7) & ~64'd7;
            if (64'(log_tail) + padded > 64'(capacity)) begin
               r.status = STATUS_FULL;
            end else begin
               r.status          = STATUS_APPENDED;
               r.sequence_number = next_seq;
               r.entry_offset    = log_tail;
               next_seq          = next_seq + 64'd1;
               log_tail          = log_tail + padded[31:0];
            end
         end
         r.free_bytes = (log_tail > capacity) ? 32'd0 : capacity - log_tail;
         crc_reg    = ALL_ONES;
         byte_tally = '0;
         awaited_results = {awaited_results, r};
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic add_word(input logic [7:0] b, input logic is_last, input logic empty_slot);
      req_type w;
      w.data_byte = b;
      w.last      = is_last;
      w.no_data   = empty_slot;
      queued_words = {queued_words, w};
      words_queued++;
   endtask

   // One well-formed entry: random bytes, stray no-byte words, last on a byte or a marker
   task automatic add_random_entry;
      int unsigned kind;
      int unsigned len;
      bit          marker;
      kind   = $urandom_range(99);
      marker = ($urandom_range(3) == 0);
      if (kind < 5) len = 0;
      else if (kind < 90) len = $urandom_range(16, 1);
      else len = $urandom_range(80, 17);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) add_word(8'($urandom_range(255)), 1'b0, 1'b1);
         add_word(8'($urandom_range(255)), (i == len - 1) && !marker, 1'b0);
      end
      if (len == 0 || marker) add_word(8'($urandom_range(255)), 1'b1, 1'b1);
   endtask

   task automatic add_random_words(input int unsigned count);
      int unsigned stop_at;
      stop_at = words_queued + count;
      while (words_queued < stop_at) add_random_entry();
   endtask

   // Wait until every word is taken and every result is back, then let the engine settle
   task automatic drain_and_settle;
      do @(negedge clock);
      while (queued_words.size() != 0 || req_valid || awaited_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      capacity = value;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Driver: offer queued words, predict on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_append(req_data);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (queued_words.size() > 0 && (steady || $urandom_range(99) >= 6)) begin
               req_valid <= 1'b1;
               req_data  <= queued_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result with the oldest prediction; drive rsp_ready
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("sequence_number", want.sequence_number, rsp_data.sequence_number);
               check_field("entry_offset", 64'(want.entry_offset), 64'(rsp_data.entry_offset));
               check_field("payload_length", 64'(want.payload_length),
                           64'(rsp_data.payload_length));
               check_field("checksum", 64'(want.checksum), 64'(rsp_data.checksum));
               check_field("free_bytes", 64'(want.free_bytes), 64'(rsp_data.free_bytes));
               case (want.status)
                  STATUS_APPENDED: appended_seen++;
                  STATUS_FULL:     full_seen++;
                  default:         empty_seen++;
               endcase
            end
         end
         // long hold-off on request, else random stalls
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_started != hold_asked) begin
            holds_started++;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 6);
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty entry, byte extremes, check string, no-byte words, marker end
      add_word(8'hA5, 1'b1, 1'b1);
      add_word(8'h00, 1'b1, 1'b0);
      add_word(8'hFF, 1'b1, 1'b0);
      for (int i = 0; i < 9; i++) add_word(8'(8'h31 + i), (i == 8), 1'b0);
      add_word(8'h5A, 1'b0, 1'b0);
      add_word(8'hC3, 1'b0, 1'b1);
      add_word(8'h3C, 1'b1, 1'b0);
      add_word(8'h81, 1'b0, 1'b1);
      for (int i = 0; i < 7; i++) add_word(8'($urandom_range(255)), 1'b0, 1'b0);
      add_word(8'h7E, 1'b1, 1'b1);
      drain_and_settle();

      // Zero capacity: every non-empty entry full, free space clamps to zero
      write_capacity(32'd0);
      add_random_entry();
      add_random_entry();
      add_word(8'h00, 1'b1, 1'b1);
      drain_and_settle();

      // Largest capacity
      write_capacity(ALL_ONES);
      add_random_words(300);
      drain_and_settle();

      // Tight capacity: log fills up; leave an entry open across the next write
      write_capacity(log_tail + 32'd600);
      add_random_words(300);
      for (int i = 0; i < 3; i++) add_word(8'($urandom_range(255)), 1'b0, 1'b0);
      drain_and_settle();

      // Capacity below the write position
      write_capacity(log_tail - 32'd8);
      add_random_words(100);
      drain_and_settle();

      // Back to the reset capacity, no idling on either side
      write_capacity(32'd65536);
      steady = 1'b1;
      add_random_words(200);
      drain_and_settle();
      steady = 1'b0;

      // Receiver holds off long enough to back up the input
      add_random_words(200);
      hold_asked++;
      drain_and_settle();
      repeat (10) @(posedge clock);

      $display("run: %0d words, %0d entries appended, %0d full, %0d empty", words_sent,
               appended_seen, full_seen, empty_seen);
      $display("run: capacities swept from 0 to all ones, incl. below the write position");
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
